[design/mbn_pkg.sv]
package mbn_pkg;

  // Width of one normalized Q1.14 result coordinate.
  localparam int NORM_W = 16;

  // Quotient bits of the per-axis division. The result magnitude never
  // exceeds 12288, so fourteen bits hold it.
  localparam int QUOT_W = 14;
  localparam int STEP_W = $clog2(QUOT_W);

  // The scale 12288 is 2^13 + 2^12, applied as two shifts.
  localparam int SCALE_SH_A = 13;
  localparam int SCALE_SH_B = 12;

  localparam int NUM_AXES = 3;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_DEGEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  // Control from the sequencer to each axis lane.
  typedef struct packed {
    logic load;
    logic clear;
    logic fetch;
    logic capture;
    logic prep;
    logic step;
  } lane_ctl_t;

endpackage

[design/mesh_bbox_normalizer_top.sv]
// Channel | Ports                                                                      | Direction
// --------+----------------------------------------------------------------------------+----------
// request | in_valid, in_ready, in_cmd, in_x/y/z_coord                                 | input
// result  | out_valid, out_ready, out_norm_x/y/z, out_is_last, out_status, out_dropped | output
//
// Load, clear and the unused command are handled in the idle state. A fetch goes
// through one memory read, the centered offset, the divider setup, one quotient
// bit per cycle in the three axis lanes, and the output register. A fetch on an
// empty store skips the read and the lanes and goes straight to the output stage.
// Reset clears the counters, the box corners, the overflow flag and the output
// valid flag at once; the vertex memory needs no clearing pass. A fetch that
// finishes while the output register is still full waits until it drains.
module mesh_bbox_normalizer_top #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic signed [COORD_BITS-1:0]          in_x_coord,
  input  logic signed [COORD_BITS-1:0]          in_y_coord,
  input  logic signed [COORD_BITS-1:0]          in_z_coord,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mbn_pkg::NORM_W-1:0]     out_norm_x,
  output logic signed [mbn_pkg::NORM_W-1:0]     out_norm_y,
  output logic signed [mbn_pkg::NORM_W-1:0]     out_norm_z,
  output logic                                  out_is_last,
  output logic [1:0]                            out_status,
  output logic                                  out_dropped
);
  import mbn_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int VW = NUM_AXES * CB;

  // Vertex store: one write port for loads, one registered read port for
  // fetches. Word layout is {z, y, x}.
  logic [VW-1:0] mem [MAX_VERTICES];
  logic [VW-1:0] rdata_r;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic          ovf_r, ovf_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CB-1:0] ext_r, ext_nxt;
  logic          pend_empty_r, pend_empty_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          pend_drop_r, pend_drop_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [NORM_W-1:0] norm_x_r, norm_x_nxt;
  logic [NORM_W-1:0] norm_y_r, norm_y_nxt;
  logic [NORM_W-1:0] norm_z_r, norm_z_nxt;
  logic              last_r, last_nxt;
  status_t           status_r, status_nxt;
  logic              drop_r, drop_nxt;

  lane_ctl_t ctl;
  logic      accept;
  logic      full;
  logic      mem_we;
  logic      mem_re;
  logic      empty_now;

  logic [NUM_AXES-1:0][CB-1:0]     load_coord;
  logic [NUM_AXES-1:0][CB-1:0]     lane_ext;
  logic [NUM_AXES-1:0][NORM_W-1:0] lane_norm;
  logic [NUM_AXES-1:0][NORM_W-1:0] merged_norm;
  logic [CB-1:0]                   ext_max;
  logic                            degen;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r >= CW'(MAX_VERTICES));
  assign empty_now = (count_r == '0) || (CW'(rp_r) >= count_r);

  assign load_coord[0] = in_x_coord;
  assign load_coord[1] = in_y_coord;
  assign load_coord[2] = in_z_coord;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mbn_lane #(
      .COORD_BITS (CB)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .load_coord (load_coord[a]),
      .rd_coord   (rdata_r[a*CB +: CB]),
      .ext_i      (ext_r),
      .extent_o   (lane_ext[a]),
      .norm_o     (lane_norm[a])
    );
  end

  mbn_merge #(
    .COORD_BITS (CB)
  ) u_merge (
    .lane_ext  (lane_ext),
    .lane_norm (lane_norm),
    .ext_i     (ext_r),
    .ext_max   (ext_max),
    .degen     (degen),
    .norm_o    (merged_norm)
  );

  // Sequencer: handles load and clear in place, and walks a fetch through
  // read, offset, divider setup, division and hand-off to the output.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    ovf_nxt        = ovf_r;
    step_nxt       = step_r;
    ext_nxt        = ext_r;
    pend_empty_nxt = pend_empty_r;
    pend_last_nxt  = pend_last_r;
    pend_drop_nxt  = pend_drop_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    norm_x_nxt     = norm_x_r;
    norm_y_nxt     = norm_y_r;
    norm_z_nxt     = norm_z_r;
    last_nxt       = last_r;
    status_nxt     = status_r;
    drop_nxt       = drop_r;
    ctl            = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                ctl.load  = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_FETCH: begin
              pend_drop_nxt  = ovf_r;
              pend_empty_nxt = empty_now;
              pend_last_nxt  = (CW'(rp_r) + CW'(1) == count_r);
              ext_nxt        = ext_max;
              if (empty_now) begin
                state_nxt = ST_OUT;
              end else begin
                mem_re    = 1'b1;
                ctl.fetch = 1'b1;
                state_nxt = ST_READ;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              rp_nxt    = '0;
              ovf_nxt   = 1'b0;
              ctl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        ctl.capture = 1'b1;
        state_nxt   = ST_PREP;
      end
      ST_PREP: begin
        ctl.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(QUOT_W - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          drop_nxt      = pend_drop_r;
          state_nxt     = ST_IDLE;
          if (pend_empty_r) begin
            norm_x_nxt = '0;
            norm_y_nxt = '0;
            norm_z_nxt = '0;
            last_nxt   = 1'b0;
            status_nxt = STAT_EMPTY;
          end else begin
            norm_x_nxt = merged_norm[0];
            norm_y_nxt = merged_norm[1];
            norm_z_nxt = merged_norm[2];
            last_nxt   = pend_last_r;
            status_nxt = degen ? STAT_DEGEN : STAT_OK;
            // Returning the final vertex empties the block.
            if (pend_last_r) begin
              count_nxt = '0;
              rp_nxt    = '0;
              ovf_nxt   = 1'b0;
              ctl.clear = 1'b1;
            end else begin
              rp_nxt = rp_r + AW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rp_r        <= '0;
      ovf_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      ovf_r       <= ovf_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ext_r        <= ext_nxt;
    pend_empty_r <= pend_empty_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_drop_r  <= pend_drop_nxt;
    norm_x_r     <= norm_x_nxt;
    norm_y_r     <= norm_y_nxt;
    norm_z_r     <= norm_z_nxt;
    last_r       <= last_nxt;
    status_r     <= status_nxt;
    drop_r       <= drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {in_z_coord, in_y_coord, in_x_coord};
    end
    if (mem_re) begin
      rdata_r <= mem[rp_r];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_norm_x  = norm_x_r;
  assign out_norm_y  = norm_y_r;
  assign out_norm_z  = norm_z_r;
  assign out_is_last = last_r;
  assign out_status  = status_r;
  assign out_dropped = drop_r;

endmodule

[design/mbn_lane.sv]
module mbn_lane #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbn_pkg::lane_ctl_t            ctl,
  input  logic signed [COORD_BITS-1:0]  load_coord,
  input  logic signed [COORD_BITS-1:0]  rd_coord,
  input  logic [COORD_BITS-1:0]         ext_i,
  output logic [COORD_BITS-1:0]         extent_o,
  output logic signed [mbn_pkg::NORM_W-1:0] norm_o
);
  import mbn_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int MW = CB + 2;
  localparam int DW = CB + 17;

  logic signed [CB-1:0] min_r, min_nxt;
  logic signed [CB-1:0] max_r, max_nxt;
  logic signed [CB:0]   sum_r, sum_nxt;
  logic                 sign_r, sign_nxt;
  logic [MW-1:0]        mag_r, mag_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [DW-1:0]        dvs_r, dvs_nxt;
  logic [QUOT_W-1:0]    q_r, q_nxt;

  logic signed [CB:0]   diff;
  logic signed [MW-1:0] n_w;
  logic [NORM_W-1:0]    q_ext;

  assign diff     = {max_r[CB-1], max_r} - {min_r[CB-1], min_r};
  assign extent_o = diff[CB-1:0];
  assign n_w      = {rd_coord[CB-1], rd_coord, 1'b0} - {sum_r[CB], sum_r};
  assign q_ext    = NORM_W'(q_r);
  assign norm_o   = sign_r ? -q_ext : q_ext;

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    sum_nxt  = sum_r;
    sign_nxt = sign_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (ctl.clear) begin
      min_nxt = {1'b0, {(CB-1){1'b1}}};
      max_nxt = {1'b1, {(CB-1){1'b0}}};
    end else if (ctl.load) begin
      if (load_coord < min_r) begin
        min_nxt = load_coord;
      end
      if (load_coord > max_r) begin
        max_nxt = load_coord;
      end
    end
    if (ctl.fetch) begin
      sum_nxt = {min_r[CB-1], min_r} + {max_r[CB-1], max_r};
    end
    if (ctl.capture) begin
      sign_nxt = n_w[MW-1];
      mag_nxt  = n_w[MW-1] ? MW'(-n_w) : MW'(n_w);
    end
    if (ctl.prep) begin
      rem_nxt = (DW'(mag_r) << SCALE_SH_A) + (DW'(mag_r) << SCALE_SH_B)
              + DW'(ext_i >> 1);
      dvs_nxt = DW'(ext_i) << (QUOT_W - 1);
      q_nxt   = '0;
    end
    if (ctl.step) begin
      // One restoring-division bit per cycle, most significant first.
      if (rem_r >= dvs_r) begin
        rem_nxt = rem_r - dvs_r;
        q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
      end
      dvs_nxt = dvs_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= {1'b0, {(CB-1){1'b1}}};
      max_r <= {1'b1, {(CB-1){1'b0}}};
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
    sum_r  <= sum_nxt;
    sign_r <= sign_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    q_r    <= q_nxt;
  end

endmodule

[design/mbn_merge.sv]
module mbn_merge #(
  parameter int COORD_BITS = 24
) (
  input  logic [mbn_pkg::NUM_AXES-1:0][COORD_BITS-1:0]      lane_ext,
  input  logic [mbn_pkg::NUM_AXES-1:0][mbn_pkg::NORM_W-1:0] lane_norm,
  input  logic [COORD_BITS-1:0]                             ext_i,
  output logic [COORD_BITS-1:0]                             ext_max,
  output logic                                              degen,
  output logic [mbn_pkg::NUM_AXES-1:0][mbn_pkg::NORM_W-1:0] norm_o
);
  import mbn_pkg::*;

  logic [COORD_BITS-1:0] ext_xy;

  // Largest extent of the three axes sets the common divisor.
  assign ext_xy  = (lane_ext[1] > lane_ext[0]) ? lane_ext[1] : lane_ext[0];
  assign ext_max = (lane_ext[2] > ext_xy) ? lane_ext[2] : ext_xy;

  // A flat box has no scale; all three results are forced to zero.
  assign degen = (ext_i == '0);

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      norm_o[a] = degen ? '0 : lane_norm[a];
    end
  end

endmodule

[dv/mesh_bbox_normalizer_top_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the bounding-box normalizer.
//
// Every request the block accepts is also applied to a behavioral copy of the
// mesh store kept here: the stored vertices, the running box corners, the
// latched extent, the read position and the overflow flag. Each fetch request
// yields one expected result, which is queued and compared field by field
// with the next result the block hands over. Load, clear and the unused
// command yield nothing.
//
// The run walks a short directed list first (reset state, the coordinate
// extremes, a degenerate box, rounding ties, a load after fetching began, a
// clear in the middle of a mesh), then fills the store past capacity to see
// loads dropped, and clears it to see the flag drop again. Random meshes
// follow: a batch of loads with a chosen spread of coordinates, then fetches
// until the mesh is drained, salted with late loads, clears, unused commands
// and fetches on an empty store. The run is split into phases that differ in
// how often the sender idles and the receiver stalls.
module mesh_bbox_normalizer_top_tb;
  import mbn_pkg::*;

  localparam int COORD_W       = 24;
  localparam int MAX_VERTS     = 1024;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 48;
  localparam int NUM_PHASES    = 4;
  localparam int NUM_DIRECTED  = 22;
  // Leave generous slack after the last expected result for anything stray to show up.
  localparam int SETTLE_CYCLES = 60;
  localparam longint LIMIT_CYCLES = 1_000_000;

  // 1.5 in Q1.14 is 24576; the numerator below is doubled, so half of it.
  localparam longint SCALE_Q14 = 12288;
  localparam longint NORM_MAX  = 32767;
  localparam longint NORM_MIN  = -32768;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;

  localparam coord_t COORD_TOP = 24'sh7FFFFF;
  localparam coord_t COORD_BOT = 24'sh800000;

  typedef struct packed {
    norm_t   nx;
    norm_t   ny;
    norm_t   nz;
    logic    last;
    status_t status;
    logic    dropped;
  } norm_result_t;

  // One directed request. When typed is set, want is the hand-written result
  // that replaces the predicted one.
  typedef struct packed {
    cmd_t         cmd;
    coord_t       x;
    coord_t       y;
    coord_t       z;
    logic         typed;
    norm_result_t want;
  } stim_row_t;

  // How the coordinates of one random mesh are spread.
  typedef enum int {
    SPREAD_FULL,
    SPREAD_WINDOW,
    SPREAD_FLAT,
    SPREAD_POW2
  } spread_t;

  localparam norm_result_t NO_CHECK      = '0;
  localparam norm_result_t EMPTY_RESULT  =
    '{16'sd0, 16'sd0, 16'sd0, 1'b0, STAT_EMPTY, 1'b0};
  localparam norm_result_t TOP_CORNER    =
    '{16'sd12288, 16'sd12288, 16'sd12288, 1'b0, STAT_OK, 1'b0};
  localparam norm_result_t BOTTOM_CORNER =
    '{-16'sd12288, -16'sd12288, -16'sd12288, 1'b1, STAT_OK, 1'b0};
  localparam norm_result_t FLAT_RESULT   =
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, STAT_DEGEN, 1'b0};

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [1:0]   in_cmd = CMD_NONE;
  coord_t       in_x_coord = '0;
  coord_t       in_y_coord = '0;
  coord_t       in_z_coord = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  norm_t        out_norm_x;
  norm_t        out_norm_y;
  norm_t        out_norm_z;
  logic         out_is_last;
  logic [1:0]   out_status;
  logic         out_dropped;

  // Idle rates of the current phase, in percent.
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  int unsigned  mismatch_count = 0;
  int unsigned  random_requests = 0;

  norm_result_t expected_norms [$];
  norm_result_t head_result;
  stim_row_t    directed_rows [NUM_DIRECTED];

  // Shadow copy of the mesh state.
  coord_t       vertex_shadow [MAX_VERTS][3];
  int unsigned  vert_count;
  int unsigned  read_ptr;
  longint       box_lo [3];
  longint       box_hi [3];
  longint       latched_extent;
  bit           extent_latched;
  bit           overflow_flag;

  mesh_bbox_normalizer_top #(
    .MAX_VERTICES(MAX_VERTS),
    .COORD_BITS  (COORD_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .in_z_coord (in_z_coord),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_norm_x (out_norm_x),
    .out_norm_y (out_norm_y),
    .out_norm_z (out_norm_z),
    .out_is_last(out_is_last),
    .out_status (out_status),
    .out_dropped(out_dropped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Both a clear request and the block emptying itself after its last vertex
  // bring everything back to the reset state, the overflow flag included.
  function automatic void clear_shadow();
    vert_count     = 0;
    read_ptr       = 0;
    latched_extent = 0;
    extent_latched = 1'b0;
    overflow_flag  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = longint'(COORD_TOP);
      box_hi[a] = longint'(COORD_BOT);
    end
  endfunction

  // Centers one coordinate on the box and scales it by 1.5 / extent. The
  // quotient rounds to nearest with ties away from zero, then saturates.
  function automatic norm_t scale_axis(coord_t v, int a);
    longint num;
    longint prod;
    longint mag;
    longint quot;
    num  = 2 * longint'(v) - (box_hi[a] + box_lo[a]);
    prod = SCALE_Q14 * num;
    mag  = (prod < 0) ? -prod : prod;
    quot = (mag + latched_extent / 2) / latched_extent;
    if (prod < 0) begin
      quot = -quot;
    end
    if (quot > NORM_MAX) begin
      quot = NORM_MAX;
    end
    if (quot < NORM_MIN) begin
      quot = NORM_MIN;
    end
    return norm_t'(quot);
  endfunction

  // Applies one accepted request to the shadow state and, for a fetch,
  // returns the result the block must produce.
  function automatic void predict_norm(input cmd_t c, input coord_t x, input coord_t y,
                                       input coord_t z, output bit produced,
                                       output norm_result_t r);
    coord_t v [3];
    longint axis_span;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    produced = 1'b0;
    r = '0;
    case (c)
      CMD_LOAD: begin
        if (vert_count >= MAX_VERTS) begin
          overflow_flag = 1'b1;
        end else begin
          for (int a = 0; a < 3; a++) begin
            vertex_shadow[vert_count][a] = v[a];
            if (longint'(v[a]) < box_lo[a]) begin
              box_lo[a] = longint'(v[a]);
            end
            if (longint'(v[a]) > box_hi[a]) begin
              box_hi[a] = longint'(v[a]);
            end
          end
          vert_count++;
          // A new vertex can grow the box, so the next fetch latches again.
          extent_latched = 1'b0;
        end
      end
      CMD_CLEAR: begin
        clear_shadow();
      end
      CMD_FETCH: begin
        produced  = 1'b1;
        r.dropped = overflow_flag;
        if (vert_count == 0 || read_ptr >= vert_count) begin
          r.status = STAT_EMPTY;
        end else begin
          if (!extent_latched) begin
            latched_extent = 0;
            for (int a = 0; a < 3; a++) begin
              axis_span = box_hi[a] - box_lo[a];
              if (axis_span > latched_extent) begin
                latched_extent = axis_span;
              end
            end
            extent_latched = 1'b1;
          end
          r.last = (read_ptr + 1 == vert_count);
          if (latched_extent == 0) begin
            r.status = STAT_DEGEN;
          end else begin
            r.nx     = scale_axis(vertex_shadow[read_ptr][0], 0);
            r.ny     = scale_axis(vertex_shadow[read_ptr][1], 1);
            r.nz     = scale_axis(vertex_shadow[read_ptr][2], 2);
            r.status = STAT_OK;
          end
          if (r.last) begin
            clear_shadow();
          end else begin
            read_ptr++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] wanted);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, wanted);
  endtask

  // Presents one request, with a random number of idle cycles ahead of it,
  // and holds it until the block takes it. Handshakes are sampled right after
  // the rising edge, before any register in the block has updated. valid is
  // left high on return so that a back-to-back request needs no extra edge.
  task automatic send_request(cmd_t c, coord_t x, coord_t y, coord_t z,
                              logic typed, norm_result_t want);
    bit produced;
    norm_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_x_coord <= x;
    in_y_coord <= y;
    in_z_coord <= z;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    predict_norm(c, x, y, z, produced, predicted);
    if (produced) begin
      expected_norms.push_back(typed ? want : predicted);
    end
  endtask

  // Holds the sender off until every expected result has come back. The
  // first edge is always waited for, so the next request starts on a new one.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_norms.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic make_vertex(spread_t spread, int base [3], int span, int idx,
                             output coord_t v [3]);
    for (int a = 0; a < 3; a++) begin
      if (spread == SPREAD_FULL) begin
        v[a] = coord_t'($urandom);
      end else begin
        v[a] = coord_t'(base[a] + int'($urandom_range(span)));
      end
    end
    // A power-of-two mesh pins the x extent to exactly the span, which makes
    // rounding ties reachable.
    if (spread == SPREAD_POW2 && idx < 2) begin
      v[0] = (idx == 0) ? coord_t'(0) : coord_t'(span);
    end
  endtask

  // One random mesh: a batch of loads, then fetches until it is drained.
  // Late loads, stray unused commands, a clear that abandons the mesh and a
  // trailing fetch on the empty store are mixed in at low rates.
  task automatic run_random_mesh();
    int      n_verts;
    int      span;
    int      remaining;
    int      idx;
    int      pick;
    int      base [3];
    spread_t spread;
    coord_t  v [3];
    n_verts = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    spread  = spread_t'($urandom_range(3));
    span    = 0;
    case (spread)
      SPREAD_WINDOW: begin
        span = 1 << $urandom_range(0, 20);
      end
      SPREAD_POW2: begin
        span = 1 << $urandom_range(1, 22);
      end
      default: begin
      end
    endcase
    for (int a = 0; a < 3; a++) begin
      base[a] = (spread == SPREAD_POW2) ? 0 :
                int'($urandom_range((1 << COORD_W) - span - 1)) - (1 << (COORD_W - 1));
    end
    for (idx = 0; idx < n_verts; idx++) begin
      make_vertex(spread, base, span, idx, v);
      send_request(CMD_LOAD, v[0], v[1], v[2], 1'b0, NO_CHECK);
      random_requests++;
    end
    remaining = n_verts;
    while (remaining > 0) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        make_vertex(spread, base, span, idx, v);
        idx++;
        send_request(CMD_LOAD, v[0], v[1], v[2], 1'b0, NO_CHECK);
        remaining++;
        random_requests++;
      end else if (pick < 7) begin
        // The unused command must leave everything as it was.
        send_request(CMD_NONE, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), 1'b0, NO_CHECK);
      end else if (pick < 9) begin
        send_request(CMD_CLEAR, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), 1'b0, NO_CHECK);
        remaining = 0;
        random_requests++;
      end else begin
        send_request(CMD_FETCH, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), 1'b0, NO_CHECK);
        remaining--;
        random_requests++;
      end
    end
    if ($urandom_range(4) == 0) begin
      send_request(CMD_FETCH, coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), 1'b0, NO_CHECK);
      random_requests++;
    end
  endtask

  // Result side: compare every accepted result with the oldest expectation,
  // and choose the ready level for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_norms.size() == 0) begin
        report_mismatch("result with nothing expected", out_status, 0);
      end else begin
        head_result = expected_norms.pop_front();
        if (out_norm_x !== head_result.nx) begin
          report_mismatch("norm_x", out_norm_x, head_result.nx);
        end
        if (out_norm_y !== head_result.ny) begin
          report_mismatch("norm_y", out_norm_y, head_result.ny);
        end
        if (out_norm_z !== head_result.nz) begin
          report_mismatch("norm_z", out_norm_z, head_result.nz);
        end
        if (out_is_last !== head_result.last) begin
          report_mismatch("is_last", out_is_last, head_result.last);
        end
        if (out_status !== head_result.status) begin
          report_mismatch("status", out_status, head_result.status);
        end
        if (out_dropped !== head_result.dropped) begin
          report_mismatch("dropped", out_dropped, head_result.dropped);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    clear_shadow();
    directed_rows = '{
      // A fetch right after reset finds the store empty.
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, EMPTY_RESULT},
      // The unused command and a clear on an empty store change nothing.
      '{CMD_NONE, COORD_TOP, COORD_BOT, COORD_TOP, 1'b0, NO_CHECK},
      '{CMD_CLEAR, COORD_BOT, COORD_TOP, COORD_BOT, 1'b0, NO_CHECK},
      // Opposite corners of the full coordinate range map to plus and
      // minus 0.75 on every axis; the second fetch empties the store.
      '{CMD_LOAD, COORD_TOP, COORD_TOP, COORD_TOP, 1'b0, NO_CHECK},
      '{CMD_LOAD, COORD_BOT, COORD_BOT, COORD_BOT, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, TOP_CORNER},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, BOTTOM_CORNER},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, EMPTY_RESULT},
      // A single vertex has a zero extent.
      '{CMD_LOAD, 24'sd5, -24'sd7, 24'sd100, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, FLAT_RESULT},
      // Extent 32768 in x; vertices at 2 and 32766 land on exact halves and
      // round away from zero. The last two loads arrive after the first
      // fetch, so the extent is latched again.
      '{CMD_LOAD, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_LOAD, 24'sd32768, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_LOAD, 24'sd2, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_LOAD, 24'sd32766, -24'sd1, 24'sd1, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      // A clear in the middle of a mesh leaves nothing to fetch.
      '{CMD_LOAD, 24'sd1, 24'sd2, 24'sd3, 1'b0, NO_CHECK},
      '{CMD_LOAD, 24'sd4, 24'sd5, 24'sd6, 1'b0, NO_CHECK},
      '{CMD_CLEAR, 24'sd0, 24'sd0, 24'sd0, 1'b0, NO_CHECK},
      '{CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, EMPTY_RESULT}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Phase 0 runs without idling, then the sender idles on its own, then
      // the receiver stalls on its own, then both idle now and then.
      case (phase)
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 73;
        end
        3: begin
          send_idle_pct  = 14;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (phase == 0) begin
        for (int i = 0; i < NUM_DIRECTED; i++) begin
          send_request(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].z, directed_rows[i].typed, directed_rows[i].want);
        end
        // Fill the store and push two loads past its end; a fetch then
        // reports the drop, and a clear takes the flag away again.
        for (int i = 0; i < MAX_VERTS + 2; i++) begin
          send_request(CMD_LOAD, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), 1'b0, NO_CHECK);
        end
        send_request(CMD_FETCH, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), 1'b0, NO_CHECK);
        send_request(CMD_CLEAR, coord_t'($urandom), coord_t'($urandom),
                     coord_t'($urandom), 1'b0, NO_CHECK);
        send_request(CMD_FETCH, 24'sd0, 24'sd0, 24'sd0, 1'b1, EMPTY_RESULT);
      end

      while (random_requests < (phase + 1) * RANDOM_ITEMS / NUM_PHASES) begin
        run_random_mesh();
      end
      wait_results_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[mesh_bbox_normalizer_top] OK");
    end else begin
      $display("[mesh_bbox_normalizer_top] ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[mesh_bbox_normalizer_top] ERROR");
    $finish;
  end

endmodule
